>>> hdl/rbpq_pkg.sv
// ----------------------------------------------------------------------------
// rbpq_pkg
// Shared types, codes and helpers for the random byte prefetch queue.
// ----------------------------------------------------------------------------
package rbpq_pkg;

  localparam int QUEUE_BYTES_DEF = 16;
  localparam int ROW_BYTES       = 8;

  // transaction function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // read size codes (log2 of bytes)
  localparam logic [1:0] SIZE_1 = 2'd0;
  localparam logic [1:0] SIZE_2 = 2'd1;
  localparam logic [1:0] SIZE_4 = 2'd2;
  localparam logic [1:0] SIZE_8 = 2'd3;

  // byte write request towards the row store
  typedef struct packed {
    logic       en;
    logic [2:0] byte_sel;
    logic [7:0] data;
  } wr_req_t;

  // mask of the low bytes that a read of the given size returns
  function automatic logic [63:0] byte_mask(input logic [1:0] lg);
    logic [63:0] m;
    unique case (lg)
      SIZE_1:  m = 64'h0000_0000_0000_00ff;
      SIZE_2:  m = 64'h0000_0000_0000_ffff;
      SIZE_4:  m = 64'h0000_0000_ffff_ffff;
      SIZE_8:  m = 64'hffff_ffff_ffff_ffff;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

  // size minus one, which is also the alignment mask (~1, ~3, ~7 inverted)
  function automatic logic [2:0] size_m1(input logic [1:0] lg);
    logic [2:0] s;
    unique case (lg)
      SIZE_1:  s = 3'd0;
      SIZE_2:  s = 3'd1;
      SIZE_4:  s = 3'd3;
      SIZE_8:  s = 3'd7;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/random_byte_prefetch_queue_unit.sv
// ----------------------------------------------------------------------------
// random_byte_prefetch_queue_unit
// Ring of random bytes kept ahead of a reader, with aligned 1/2/4/8-byte reads.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle; busy stays low. Each result is
// strobed on out_strobe in the cycle after its transaction is accepted, a
// delay set by the registered read of the row memory that holds the ring.
// The receiver cannot stall, so a result must be captured in the cycle it
// is shown. The ring reads as zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
module random_byte_prefetch_queue_unit
  import rbpq_pkg::*;
#(
  parameter int QUEUE_BYTES = QUEUE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_random_byte,
  input  logic [1:0]  in_read_size_log2,
  output logic        out_strobe,
  output logic [63:0] out_read_value,
  output logic        out_generator_run,
  output logic        out_push_dropped
);

  localparam int ROWS   = QUEUE_BYTES / ROW_BYTES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_W  = $clog2(QUEUE_BYTES);
  localparam int DW     = POS_W + 2;
  localparam logic signed [DW-1:0] D_MAX = DW'(QUEUE_BYTES);
  localparam logic signed [DW-1:0] D_MIN = -D_MAX;

  logic                 accept;
  logic [POS_W-1:0]     read_pos_r, read_pos_nxt;
  logic signed [DW-1:0] deficit_r, deficit_nxt;
  logic                 run_r, run_nxt;

  logic                 out_strobe_r;
  logic                 out_rd_r;
  logic [2:0]           out_off_r;
  logic [1:0]           out_lg_r;
  logic                 out_drop_r;
  logic                 drop_nxt;

  logic [POS_W-1:0]     pad;
  logic [POS_W-1:0]     aligned_pos;
  logic [POS_W-1:0]     slot;
  logic [POS_W-1:0]     rd_row_full, wr_row_full;
  logic [3:0]           passed;
  logic signed [DW:0]   dsum;
  logic signed [DW-1:0] ddec;
  wr_req_t              wr_req;
  logic                 rd_en;
  logic [63:0]          rd_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // read alignment: padding up to the next multiple of the size
  assign pad         = (~read_pos_r + POS_W'(1)) & POS_W'(size_m1(in_read_size_log2));
  assign aligned_pos = read_pos_r + pad;
  assign passed      = {1'b0, pad[2:0]} + {1'b0, size_m1(in_read_size_log2)} + 4'd1;
  assign dsum        = {deficit_r[DW-1], deficit_r} + $signed((DW + 1)'(passed));
  assign ddec        = deficit_r - DW'(1);

  // oldest consumed slot lies deficit places behind the reader, mod ring size
  assign slot        = read_pos_r - deficit_r[POS_W-1:0];
  assign wr_row_full = slot >> 3;
  assign rd_row_full = aligned_pos >> 3;

  always_comb begin
    read_pos_nxt = read_pos_r;
    deficit_nxt  = deficit_r;
    run_nxt      = run_r;
    drop_nxt     = 1'b0;
    wr_req       = '{en: 1'b0, byte_sel: slot[2:0], data: in_random_byte};
    rd_en        = 1'b0;
    if (accept) begin
      if (in_func == FUNC_READ) begin
        rd_en        = 1'b1;
        read_pos_nxt = aligned_pos + POS_W'(4'd1 + {1'b0, size_m1(in_read_size_log2)});
        deficit_nxt  = (dsum > (DW + 1)'(D_MAX)) ? D_MAX : dsum[DW-1:0];
        run_nxt      = 1'b1;
      end else if (deficit_r == D_MIN) begin
        drop_nxt = 1'b1;
      end else begin
        wr_req.en   = 1'b1;
        deficit_nxt = ddec;
        if (ddec <= 0) begin
          run_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_pos_r   <= '0;
      deficit_r    <= D_MAX;
      run_r        <= 1'b1;
      out_strobe_r <= 1'b0;
    end else begin
      read_pos_r   <= read_pos_nxt;
      deficit_r    <= deficit_nxt;
      run_r        <= run_nxt;
      out_strobe_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd_r   <= (in_func == FUNC_READ);
      out_off_r  <= aligned_pos[2:0];
      out_lg_r   <= in_read_size_log2;
      out_drop_r <= drop_nxt;
    end
  end

  rbpq_store #(
    .QUEUE_BYTES(QUEUE_BYTES)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_req (wr_req),
    .wr_row (wr_row_full[ROW_AW-1:0]),
    .rd_en  (rd_en),
    .rd_row (rd_row_full[ROW_AW-1:0]),
    .rd_data(rd_data)
  );

  assign out_strobe        = out_strobe_r;
  assign out_read_value    = out_rd_r ?
                             ((rd_data >> {out_off_r, 3'b000}) & byte_mask(out_lg_r)) : 64'h0;
  assign out_generator_run = run_r;
  assign out_push_dropped  = out_drop_r;

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("result strobe missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe)
    else $error("result strobe without a transaction");

  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_rd_r) |-> (out_read_value == 64'h0))
    else $error("push transaction returned a read value");

  a_deficit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (deficit_r <= D_MAX) && (deficit_r >= D_MIN))
    else $error("refill deficit out of range");

  a_drop_only_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rd_r) |-> !out_push_dropped)
    else $error("read transaction flagged as dropped");

endmodule

>>> hdl/rbpq_store.sv
// ----------------------------------------------------------------------------
// rbpq_store
// Byte ring held as 8-byte rows in a synchronous memory with byte writes.
// Per-row valid bits make rows read as zero until first written.
// ----------------------------------------------------------------------------
module rbpq_store
  import rbpq_pkg::*;
#(
  parameter int QUEUE_BYTES = QUEUE_BYTES_DEF,
  localparam int ROWS   = QUEUE_BYTES / ROW_BYTES,
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wr_req_t           wr_req,
  input  logic [ROW_AW-1:0] wr_row,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_row,
  output logic [63:0]       rd_data
);

  logic [63:0]     mem [ROWS];
  logic [ROWS-1:0] valid_r;
  logic [63:0]     rd_data_r;
  logic            rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      if (valid_r[wr_row]) begin
        mem[wr_row][{wr_req.byte_sel, 3'b000} +: 8] <= wr_req.data;
      end else begin
        // first write to a row: the other bytes take their reset value
        mem[wr_row] <= {56'h0, wr_req.data} << {wr_req.byte_sel, 3'b000};
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        valid_r[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_row];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 64'h0;

endmodule
